/* hw/rtl/max_flow_dfs_augment_defines.svh */
// assertion macros for the max flow block
`ifndef MAX_FLOW_DFS_AUGMENT_DEFINES_SVH
`define MAX_FLOW_DFS_AUGMENT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/mfd_pkg.sv */
// shared constants for the max flow block
`default_nettype none
package mfd_pkg;
  localparam int DEF_MAX_VERTICES = 128;
  localparam int DEF_MAX_EDGES    = 1024;

  localparam int VERT_W   = 7;
  localparam int CAP_W    = 30;
  localparam int FLOW_W   = 31;
  localparam int AMT_W    = 30;
  localparam int TOTAL_W  = 48;
  localparam int STATUS_W = 2;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 56;
  localparam int EPOCH_W  = 8;

  localparam logic [AMT_W-1:0]  FLOW_LIMIT = 30'd1000000007;
  localparam logic [VERT_W-1:0] SINK_RESET = 7'd127;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SAME  = 2'd3;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_RUN = 1'b1;
endpackage
`default_nettype wire

/* hw/rtl/mfd_ram.sv */
// generic single write, single read ram with registered read (old data on collision)
`default_nettype none
module mfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]      wr_data,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]      rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end
endmodule
`default_nettype wire

/* hw/rtl/max_flow_dfs_augment.sv */
// max flow by depth-first augmenting paths: edge store, search sequencer, result register
// edge insert: INS0 to INS3, then FIN; error cases go straight to FIN; flow run: SRCH0,
// SRCH1 per search, EXAM, VISR, EVAL per arc tried, PUSH per push, POP1 to POP3 per pop,
// AUGR, AUGP, AUGW per path frame; one item is in work at a time and the sequencer owns
// every ram port; reset: synchronous active low, clears lists (valid bits), edge count,
// sink 127, then a pass wipes the visited marks; it repeats when the mark epoch wraps
`default_nettype none
`include "max_flow_dfs_augment_defines.svh"
module max_flow_dfs_augment #(
  parameter int MAX_VERTICES = mfd_pkg::DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = mfd_pkg::DEF_MAX_EDGES
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // in_tdata: end_a[6:0], end_b[13:7], capacity[43:14], source[50:44], zero pad
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [mfd_pkg::IN_W-1:0]   in_tdata,
  // in_tuser: func[0]
  input  wire logic [0:0]                 in_tuser,
  // out_tdata: status[1:0], total_flow[49:2], zero pad
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic      [mfd_pkg::OUT_W-1:0]  out_tdata,
  // sink vertex write
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [mfd_pkg::VERT_W-1:0] cfg_data
);
  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int EW    = $clog2(MAX_EDGES + 1);
  localparam int PW    = EW + 1;                 // arc pointer incl. null
  localparam int AW    = $clog2(2 * MAX_EDGES);  // arc ram address
  localparam int PAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int DW    = $clog2(MAX_VERTICES + 1);
  localparam int CAP_W = mfd_pkg::CAP_W;
  localparam int FL_W  = mfd_pkg::FLOW_W;
  localparam int AMT_W = mfd_pkg::AMT_W;
  localparam int TW    = mfd_pkg::TOTAL_W;
  localparam int EPW   = mfd_pkg::EPOCH_W;
  localparam int PR_W  = CAP_W + FL_W;
  localparam logic [PW-1:0] ARC_NULL = PW'(2 * MAX_EDGES);

  typedef struct packed {
    logic [PW-1:0]    arc;
    logic [AMT_W-1:0] amt;
  } frame_t;

  typedef enum logic [4:0] {
    IDLE, INS0, INS1, INS2, INS3, SRCH0, SRCH1, EXAM, VISR, EVAL, PUSH,
    POP1, POP2, POP3, AUGR, AUGP, AUGW, FIN, CLR
  } state_t;

  state_t st_r;

  // latched item
  logic [VW-1:0]    a_r, b_r, src_r;
  logic [CAP_W-1:0] cap_r;
  logic [mfd_pkg::VERT_W-1:0] sink_r;

  // control state
  logic [EW-1:0]           edge_count_r;
  logic [MAX_VERTICES-1:0] lv_r;       // list non-empty per vertex
  logic [EPW-1:0]          epoch_r;    // mark value of the current search, 0 = cleared
  logic [VW-1:0]           clr_r;
  logic                    clr_back_r; // wipe pass resumes a search
  logic                    had_a_r, had_b_r;
  logic [DW-1:0]           depth_r, idx_r;
  logic [PW-1:0]           top_arc_r, arc_r;
  logic [AMT_W-1:0]        top_amt_r, amt_r;
  logic [VW-1:0]           to_r;
  logic [TW-1:0]           total_r;
  logic [mfd_pkg::STATUS_W-1:0] status_r;
  logic                    out_valid_r;
  logic [mfd_pkg::OUT_W-1:0] out_data_r;

  // ram ports
  logic            tgt_we, nxt_we, pr_we, fst_we, lst_we, stk_we, vis_we;
  logic [AW-1:0]   tgt_wa, nxt_wa, arc_ra;
  logic [VW-1:0]   tgt_wd, tgt_q;
  logic [PW-1:0]   nxt_wd, nxt_q, fst_wd, fst_q, lst_wd, lst_q;
  logic [PAW-1:0]  pr_wa, pr_ra;
  logic [PR_W-1:0] pr_wd, pr_q;
  logic [VW-1:0]   fst_wa, fst_ra, lst_wa, lst_ra;
  logic [VW-1:0]   stk_wa, stk_ra;
  frame_t          stk_wd, stk_q;
  logic [VW-1:0]   vis_wa, vis_ra;
  logic [EPW-1:0]  vis_wd, vis_q;

  // input field views
  logic             in_func;
  logic [mfd_pkg::VERT_W-1:0] in_a, in_b, in_src;
  logic [CAP_W-1:0] in_cap;
  logic             in_fire;

  assign in_func = in_tuser[0];
  assign in_a    = in_tdata[6:0];
  assign in_b    = in_tdata[13:7];
  assign in_cap  = in_tdata[43:14];
  assign in_src  = in_tdata[50:44];
  assign in_tready = (st_r == IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // arcs of the edge being inserted
  logic [PW-1:0] arc0, arc1;
  assign arc0 = {edge_count_r, 1'b0};
  assign arc1 = {edge_count_r, 1'b1};

  // spare capacity of the top arc and the candidate amount
  logic signed [31:0] cap_s, flow_s, room;
  logic [AMT_W-1:0]   amt_c;
  logic               seen_c, hit;
  assign cap_s  = $signed({2'b00, pr_q[PR_W-1:FL_W]});
  assign flow_s = $signed({pr_q[FL_W-1], pr_q[FL_W-1:0]});
  assign room   = top_arc_r[0] ? (cap_s + flow_s) : (cap_s - flow_s);
  assign amt_c  = (room < $signed({2'b00, top_amt_r})) ? room[AMT_W-1:0] : top_amt_r;
  // a vertex is visited when its mark carries the current epoch
  assign seen_c = (vis_q == epoch_r);
  assign hit    = !seen_c && (room > 32'sd0);

  // flow update along the path
  logic signed [31:0] new_flow;
  assign new_flow = arc_r[0] ? (flow_s - $signed({2'b00, amt_r}))
                             : (flow_s + $signed({2'b00, amt_r}));

  // saturating total
  logic [TW:0] sum_c;
  assign sum_c = {1'b0, total_r} + (TW + 1)'(amt_r);

  logic [PW-1:0] aug_arc;
  assign aug_arc = (idx_r == depth_r - DW'(1)) ? top_arc_r : stk_q.arc;

  always_comb begin
    tgt_we = 1'b0; tgt_wa = '0; tgt_wd = '0;
    nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0;
    arc_ra = AW'(top_arc_r);
    pr_we  = 1'b0; pr_wa = '0; pr_wd = '0;
    pr_ra  = PAW'(top_arc_r >> 1);
    fst_we = 1'b0; fst_wa = '0; fst_wd = '0; fst_ra = src_r;
    lst_we = 1'b0; lst_wa = '0; lst_wd = '0; lst_ra = a_r;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0;
    stk_ra = VW'(depth_r - DW'(1));
    vis_we = 1'b0; vis_wa = '0; vis_wd = '0; vis_ra = tgt_q;
    unique case (st_r)
      INS0: begin
        tgt_we = 1'b1; tgt_wa = AW'(arc0); tgt_wd = b_r;
        nxt_we = 1'b1; nxt_wa = AW'(arc0); nxt_wd = ARC_NULL;
        pr_we  = 1'b1; pr_wa = PAW'(edge_count_r); pr_wd = {cap_r, {FL_W{1'b0}}};
        lst_ra = a_r;
        lst_we = 1'b1; lst_wa = a_r; lst_wd = arc0;
        fst_we = !lv_r[a_r]; fst_wa = a_r; fst_wd = arc0;
      end
      INS1: begin
        nxt_we = had_a_r; nxt_wa = AW'(lst_q); nxt_wd = arc0;
      end
      INS2: begin
        tgt_we = 1'b1; tgt_wa = AW'(arc1); tgt_wd = a_r;
        nxt_we = 1'b1; nxt_wa = AW'(arc1); nxt_wd = ARC_NULL;
        lst_ra = b_r;
        lst_we = 1'b1; lst_wa = b_r; lst_wd = arc1;
        fst_we = !lv_r[b_r]; fst_wa = b_r; fst_wd = arc1;
      end
      INS3: begin
        nxt_we = had_b_r; nxt_wa = AW'(lst_q); nxt_wd = arc1;
      end
      SRCH0: begin
        fst_ra = src_r;
        // mark the source with the next epoch
        vis_we = (epoch_r != '1); vis_wa = src_r; vis_wd = epoch_r + EPW'(1);
      end
      VISR: vis_ra = tgt_q;
      EVAL: begin
        fst_ra = tgt_q;
        stk_wa = VW'(depth_r - DW'(1));
        stk_wd = '{arc: top_arc_r, amt: top_amt_r};
        stk_we = hit && (tgt_q != VW'(sink_r)) && (depth_r < DW'(MAX_VERTICES));
        vis_we = stk_we; vis_wa = tgt_q; vis_wd = epoch_r;
      end
      POP2: arc_ra = AW'(stk_q.arc);
      AUGR: stk_ra = VW'(idx_r);
      AUGP: pr_ra = PAW'(aug_arc >> 1);
      AUGW: begin
        pr_we = 1'b1; pr_wa = PAW'(arc_r >> 1);
        pr_wd = {pr_q[PR_W-1:FL_W], new_flow[FL_W-1:0]};
      end
      CLR: begin
        vis_we = 1'b1; vis_wa = clr_r; vis_wd = '0;
      end
      default: ;
    endcase
  end

  mfd_ram #(.WIDTH(VW), .DEPTH(2 * MAX_EDGES)) u_tgt_ram (
    .clk, .wr_en(tgt_we), .wr_addr(tgt_wa), .wr_data(tgt_wd),
    .rd_addr(arc_ra), .rd_data(tgt_q));
  mfd_ram #(.WIDTH(PW), .DEPTH(2 * MAX_EDGES)) u_nxt_ram (
    .clk, .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
    .rd_addr(arc_ra), .rd_data(nxt_q));
  mfd_ram #(.WIDTH(PR_W), .DEPTH(MAX_EDGES)) u_pair_ram (
    .clk, .wr_en(pr_we), .wr_addr(pr_wa), .wr_data(pr_wd),
    .rd_addr(pr_ra), .rd_data(pr_q));
  mfd_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_first_ram (
    .clk, .wr_en(fst_we), .wr_addr(fst_wa), .wr_data(fst_wd),
    .rd_addr(fst_ra), .rd_data(fst_q));
  mfd_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_last_ram (
    .clk, .wr_en(lst_we), .wr_addr(lst_wa), .wr_data(lst_wd),
    .rd_addr(lst_ra), .rd_data(lst_q));
  mfd_ram #(.WIDTH(PW + AMT_W), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk, .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
    .rd_addr(stk_ra), .rd_data(stk_q));
  mfd_ram #(.WIDTH(EPW), .DEPTH(MAX_VERTICES)) u_mark_ram (
    .clk, .wr_en(vis_we), .wr_addr(vis_wa), .wr_data(vis_wd),
    .rd_addr(vis_ra), .rd_data(vis_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= CLR;
      sink_r       <= mfd_pkg::SINK_RESET;
      edge_count_r <= '0;
      lv_r         <= '0;
      epoch_r      <= '0;
      clr_r        <= '0;
      clr_back_r   <= 1'b0;
      depth_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sink_r <= cfg_data;
      end
      if (out_valid_r && out_tready && st_r != FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        IDLE: begin
          if (in_fire) begin
            a_r     <= VW'(in_a);
            b_r     <= VW'(in_b);
            src_r   <= VW'(in_src);
            cap_r   <= in_cap;
            total_r <= '0;
            status_r <= mfd_pkg::STATUS_OK;
            st_r    <= FIN;
            if (in_func == mfd_pkg::FUNC_ADD) begin
              if (int'(in_a) >= MAX_VERTICES || int'(in_b) >= MAX_VERTICES) begin
                status_r <= mfd_pkg::STATUS_RANGE;
              end else if (int'(edge_count_r) >= MAX_EDGES) begin
                status_r <= mfd_pkg::STATUS_FULL;
              end else begin
                st_r <= INS0;
              end
            end else begin
              if (int'(in_src) >= MAX_VERTICES || int'(sink_r) >= MAX_VERTICES) begin
                status_r <= mfd_pkg::STATUS_RANGE;
              end else if (in_src == sink_r) begin
                status_r <= mfd_pkg::STATUS_SAME;
              end else begin
                st_r <= SRCH0;
              end
            end
          end
        end
        INS0: begin
          had_a_r <= lv_r[a_r];
          lv_r[a_r] <= 1'b1;
          st_r <= INS1;
        end
        INS1: st_r <= INS2;
        INS2: begin
          had_b_r <= lv_r[b_r];
          lv_r[b_r] <= 1'b1;
          st_r <= INS3;
        end
        INS3: begin
          edge_count_r <= edge_count_r + EW'(1);
          st_r <= FIN;
        end
        // fresh search from the source: a new epoch clears all marks at once
        SRCH0: begin
          if (epoch_r == '1) begin
            // epoch would wrap onto stale marks: wipe them, then start over
            epoch_r    <= '0;
            clr_r      <= '0;
            clr_back_r <= 1'b1;
            st_r       <= CLR;
          end else begin
            epoch_r <= epoch_r + EPW'(1);
            depth_r <= DW'(1);
            st_r    <= SRCH1;
          end
        end
        SRCH1: begin
          top_arc_r <= lv_r[src_r] ? fst_q : ARC_NULL;
          top_amt_r <= mfd_pkg::FLOW_LIMIT;
          st_r <= EXAM;
        end
        EXAM: begin
          if (top_arc_r >= ARC_NULL) begin
            depth_r <= depth_r - DW'(1);
            st_r <= POP1;
          end else begin
            st_r <= VISR;
          end
        end
        // target known, fetch its mark
        VISR: st_r <= EVAL;
        EVAL: begin
          amt_r <= amt_c;
          to_r  <= tgt_q;
          priority if (hit && tgt_q == VW'(sink_r)) begin
            idx_r <= '0;
            st_r  <= AUGR;
          end else if (hit && depth_r < DW'(MAX_VERTICES)) begin
            st_r <= PUSH;
          end else begin
            top_arc_r <= nxt_q;
            st_r <= EXAM;
          end
        end
        PUSH: begin
          top_arc_r <= lv_r[to_r] ? fst_q : ARC_NULL;
          top_amt_r <= amt_r;
          depth_r   <= depth_r + DW'(1);
          st_r <= EXAM;
        end
        POP1: begin
          if (depth_r == '0) begin
            // no path left: run ends
            st_r <= FIN;
          end else begin
            st_r <= POP2;
          end
        end
        POP2: begin
          top_amt_r <= stk_q.amt;
          st_r <= POP3;
        end
        POP3: begin
          top_arc_r <= nxt_q;
          st_r <= EXAM;
        end
        AUGR: st_r <= AUGP;
        AUGP: begin
          arc_r <= aug_arc;
          st_r  <= AUGW;
        end
        AUGW: begin
          if (idx_r == depth_r - DW'(1)) begin
            total_r <= sum_c[TW] ? {TW{1'b1}} : sum_c[TW-1:0];
            st_r <= SRCH0;
          end else begin
            idx_r <= idx_r + DW'(1);
            st_r  <= AUGR;
          end
        end
        FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= mfd_pkg::OUT_W'({total_r, status_r});
            st_r <= IDLE;
          end
        end
        // one mark per cycle back to the cleared value
        CLR: begin
          if (clr_r == VW'(MAX_VERTICES - 1)) begin
            clr_back_r <= 1'b0;
            st_r <= clr_back_r ? SRCH0 : IDLE;
          end else begin
            clr_r <= clr_r + VW'(1);
          end
        end
        default: st_r <= IDLE;
      endcase
    end
  end

  `MFD_ASSERT_NOW(a_depth_bound, st_r != IDLE, depth_r <= DW'(MAX_VERTICES), "stack depth overflow")
  `MFD_ASSERT_NOW(a_beat_from_fin, $rose(out_valid_r), $past(st_r == FIN), "result beat without finish")
  `MFD_ASSERT_NOW(a_epoch_live, st_r == EVAL, epoch_r != '0, "search without a live mark epoch")

endmodule
`default_nettype wire

/* tb/testbench.sv */
// self-checking regression for the max flow block: edge loads, flow runs, sink changes
`default_nettype none
module testbench;

  localparam int NV         = mfd_pkg::DEF_MAX_VERTICES;
  localparam int NE         = mfd_pkg::DEF_MAX_EDGES;
  localparam int ARC_NONE   = 2 * NE;
  localparam longint TOTAL_SAT = 64'hFFFF_FFFF_FFFF;
  localparam int SETTLE     = 40;        // idle cycles before a sink write, the back-pressure test and at the end
  localparam int CYCLE_LIMIT = 20000000; // watchdog

  typedef struct packed {
    logic [mfd_pkg::STATUS_W-1:0] status;
    logic [mfd_pkg::TOTAL_W-1:0]  total;
  } flow_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [mfd_pkg::IN_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [mfd_pkg::OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mfd_pkg::VERT_W-1:0] cfg_data = '0;

  max_flow_dfs_augment uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- graph shadow
  int unsigned arc_to [2*NE];
  int unsigned arc_nx [2*NE];
  int unsigned edge_cap [NE];
  int          edge_flow [NE];   // signed flow on the even arc
  int unsigned list_head [NV];
  int unsigned list_tail [NV];
  bit          seen [NV];
  int unsigned dfs_vert [NV];
  int unsigned dfs_arc [NV];
  longint      dfs_amt [NV];
  int unsigned edges_stored;
  int unsigned sink_now;

  flow_result_t pending_results[$];
  int errors = 0;
  int hold_off = 0;       // receiver hold-off, cycles left
  bit quiet = 1'b0;       // no idling on either side
  longint cycles = 0;

  function automatic longint spare_of(int unsigned arc);
    longint c, f;
    c = edge_cap[arc >> 1];
    f = edge_flow[arc >> 1];
    return arc[0] ? c + f : c - f;
  endfunction

  function automatic void append_arc(int unsigned v, int unsigned arc, int unsigned to);
    arc_to[arc] = to;
    arc_nx[arc] = ARC_NONE;
    if (list_head[v] == ARC_NONE) list_head[v] = arc;
    else arc_nx[list_tail[v]] = arc;
    list_tail[v] = arc;
  endfunction

  // one depth-first search; pushes and returns the bottleneck, zero when no path is left
  function automatic longint find_and_push(int unsigned src, int unsigned snk);
    int unsigned depth, arc, to, k;
    longint room, amt;
    depth = 1;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[src] = 1'b1;
    dfs_vert[0] = src;
    dfs_arc[0] = list_head[src];
    dfs_amt[0] = mfd_pkg::FLOW_LIMIT;
    while (depth > 0) begin
      arc = dfs_arc[depth-1];
      if (arc >= ARC_NONE) begin
        depth--;
        if (depth > 0) dfs_arc[depth-1] = arc_nx[dfs_arc[depth-1]];
        continue;
      end
      to = arc_to[arc];
      room = spare_of(arc);
      if (!seen[to] && room > 0) begin
        amt = (room < dfs_amt[depth-1]) ? room : dfs_amt[depth-1];
        if (to == snk) begin
          for (k = 0; k < depth; k++) begin
            if (dfs_arc[k][0]) edge_flow[dfs_arc[k] >> 1] -= int'(amt);
            else edge_flow[dfs_arc[k] >> 1] += int'(amt);
          end
          return amt;
        end
        if (depth < NV) begin
          seen[to] = 1'b1;
          dfs_vert[depth] = to;
          dfs_arc[depth] = list_head[to];
          dfs_amt[depth] = amt;
          depth++;
          continue;
        end
      end
      dfs_arc[depth-1] = arc_nx[arc];
    end
    return 0;
  endfunction

  function automatic flow_result_t predict_result(logic func, int unsigned a, int unsigned b,
                                                  int unsigned cap, int unsigned src);
    flow_result_t r;
    longint total, add;
    r = '0;
    total = 0;
    if (func == mfd_pkg::FUNC_ADD) begin
      if (a >= NV || b >= NV) r.status = mfd_pkg::STATUS_RANGE;
      else if (edges_stored >= NE) r.status = mfd_pkg::STATUS_FULL;
      else begin
        edge_cap[edges_stored] = cap;
        edge_flow[edges_stored] = 0;
        append_arc(a, 2 * edges_stored, b);
        append_arc(b, 2 * edges_stored + 1, a);
        edges_stored++;
      end
    end else begin
      if (src >= NV || sink_now >= NV) r.status = mfd_pkg::STATUS_RANGE;
      else if (src == sink_now) r.status = mfd_pkg::STATUS_SAME;
      else begin
        add = find_and_push(src, sink_now);
        while (add > 0) begin
          total += add;
          if (total > TOTAL_SAT) total = TOTAL_SAT;
          add = find_and_push(src, sink_now);
        end
        foreach (seen[i]) seen[i] = 1'b0;
      end
      r.total = total[mfd_pkg::TOTAL_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  always @(posedge clk) begin
    flow_result_t want;
    logic [mfd_pkg::STATUS_W-1:0] got_status;
    logic [mfd_pkg::TOTAL_W-1:0] got_total;
    got_status = out_tdata[1:0];
    got_total = out_tdata[49:2];
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result beat status %0d total %0d", got_status, got_total));
      end else begin
        want = pending_results.pop_front();
        if (got_status != want.status)
          report($sformatf("status got %0d want %0d", got_status, want.status));
        if (got_total != want.total)
          report($sformatf("total_flow got %0d want %0d", got_total, want.total));
      end
    end
  end

  // receiver ready: random stalls, occasional long ones, and the requested hold-off
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else if (quiet) begin
      out_tready <= 1'b1;
    end else if (r < 2) begin
      hold_off <= $urandom_range(15, 60);
      out_tready <= 1'b0;
    end else begin
      out_tready <= (r < 75);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("max_flow_dfs_augment regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // offer one item, wait until it is accepted, log the expected result, then sometimes idle a while
  task automatic send_item(input logic func, input int unsigned a, input int unsigned b,
                           input int unsigned cap, input int unsigned src);
    int gap;
    in_tuser <= func;
    in_tdata <= {5'd0, src[6:0], cap[29:0], b[6:0], a[6:0]};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), predict_result(func, a, b, cap, src));
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_sink(input int unsigned v);
    drain();
    cfg_data <= v[6:0];
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sink_now = v;
  endtask

  function automatic int unsigned pick_cap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 100);
    if (r < 65) return $urandom_range(0, 30'h3FFF_FFFF);
    if (r < 75) return 0;
    if (r < 85) return 30'h3FFF_FFFF;
    if (r < 92) return 1000000006;
    return $urandom_range(1000, 100000);
  endfunction

  // extremes, capacity above the push limit, self loops, source equal to sink
  task automatic test_directed();
    send_item(mfd_pkg::FUNC_RUN, 0, 0, 0, 127);                 // source equals reset sink
    send_item(mfd_pkg::FUNC_RUN, 0, 0, 0, 5);                   // no edges at all
    send_item(mfd_pkg::FUNC_ADD, 0, 127, 30'h3FFF_FFFF, 0);     // pushes the limit, then the rest
    send_item(mfd_pkg::FUNC_RUN, 0, 0, 0, 0);
    send_item(mfd_pkg::FUNC_ADD, 3, 3, 50, 0);                  // self loop
    send_item(mfd_pkg::FUNC_ADD, 127, 127, 0, 0);
    send_item(mfd_pkg::FUNC_ADD, 127, 3, 1000000006, 0);
    send_item(mfd_pkg::FUNC_ADD, 0, 3, 1, 127);
    send_item(mfd_pkg::FUNC_RUN, 0, 0, 0, 3);
    send_item(mfd_pkg::FUNC_RUN, 0, 0, 0, 0);                   // nothing left to push
    write_sink(0);
    send_item(mfd_pkg::FUNC_RUN, 0, 0, 0, 127);                 // uses the reverse arcs
    send_item(mfd_pkg::FUNC_RUN, 127, 127, 30'h3FFF_FFFF, 0);   // source equals sink
    send_item(mfd_pkg::FUNC_ADD, 3, 0, 0, 127);                 // zero capacity
    send_item(mfd_pkg::FUNC_RUN, 0, 0, 0, 3);
  endtask

  // graphs kept inside one band of vertices per sink setting, with some stray items
  task automatic test_random_bands();
    int unsigned lo, hi, a, b, s;
    int r;
    for (int band = 0; band < 10; band++) begin
      lo = (band == 9) ? 116 : band * 12;
      hi = lo + 11;
      if (band == 0) write_sink(0);
      else if (band == 9) write_sink(127);
      else write_sink($urandom_range(lo, hi));
      quiet = (band == 4);
      for (int n = 0; n < 66; n++) begin
        r = $urandom_range(0, 99);
        a = $urandom_range(lo, hi);
        b = $urandom_range(lo, hi);
        s = $urandom_range(lo, hi);
        if (r < 82) send_item(mfd_pkg::FUNC_ADD, a, b, pick_cap(), $urandom_range(0, 127));
        else if (r < 94) send_item(mfd_pkg::FUNC_RUN, $urandom_range(0, 127),
                                   $urandom_range(0, 127),
                                   $urandom_range(0, 30'h3FFF_FFFF), s);
        else if (r < 97) send_item(mfd_pkg::FUNC_ADD, $urandom_range(0, 127), b, pick_cap(),
                                   $urandom_range(0, 127));
        else send_item(mfd_pkg::FUNC_RUN, 0, 0, 0, $urandom_range(0, 127));
      end
      quiet = 1'b0;
    end
  endtask

  // receiver holds off while inserts keep coming, so the input stalls
  task automatic test_backpressure();
    drain();
    hold_off = 400;
    quiet = 1'b1;
    for (int n = 0; n < 20; n++)
      send_item(mfd_pkg::FUNC_ADD, $urandom_range(60, 71), $urandom_range(60, 71),
                pick_cap(), 0);
    quiet = 1'b0;
    send_item(mfd_pkg::FUNC_RUN, 0, 0, 0, 65);
  endtask

  // fill the edge table with zero-capacity self loops, then overflow it
  task automatic test_full_table();
    int unsigned v;
    write_sink(50);
    while (edges_stored < NE) begin
      v = $urandom_range(40, 50);
      send_item(mfd_pkg::FUNC_ADD, v, v, 0, 0);
    end
    send_item(mfd_pkg::FUNC_ADD, 40, 50, 30'h3FFF_FFFF, 0);
    send_item(mfd_pkg::FUNC_ADD, 127, 0, 5, 0);
    send_item(mfd_pkg::FUNC_RUN, 0, 0, 0, 41);
    send_item(mfd_pkg::FUNC_ADD, 0, 127, 1, 0);
  endtask

  initial begin
    sink_now = mfd_pkg::SINK_RESET;
    edges_stored = 0;
    foreach (list_head[i]) begin
      list_head[i] = ARC_NONE;
      list_tail[i] = ARC_NONE;
      seen[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_bands();
    test_backpressure();
    test_full_table();
    drain();
    if (errors == 0) begin
      $display("max_flow_dfs_augment regression: pass");
    end else begin
      $display("max_flow_dfs_augment regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/mfd_pkg.sv
hw/rtl/mfd_ram.sv
hw/rtl/max_flow_dfs_augment.sv
tb/testbench.sv
